>>> rtl/ptsched_pkg.sv
// shared types and constants of the priority task scheduler
package ptsched_pkg;

	localparam int MAX_TASKS = 8;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = 4;
	localparam int TIME_W    = 16;
	localparam int BURST_W   = 8;
	localparam int PRIO_W    = 8;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;

	localparam logic [TIME_W-1:0] TIME_MAX    = '1;
	localparam logic [CNT_W-1:0]  COUNT_LIMIT = CNT_W'(MAX_TASKS);

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD    = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREEMPT = 1'b0,
		REG_COUNT   = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESTART,
		ST_HOLD,
		ST_SCAN_ARR,
		ST_SCAN_PRI,
		ST_UPDATE,
		ST_TA,
		ST_WT,
		ST_DONE
	} state_t;

endpackage

>>> rtl/priority_task_scheduler_top.sv
// priority task scheduler: task table, slot scan sequencer and completion stats
//
// channel   direction  handshake                    payload
// command   in         start & !busy                mode, slot, arrival_time, burst_time,
//                                                   priority_req
// result    out        result_valid, one cycle      ran, task_id, finished, finish_time,
//                                                   turnaround_time, waiting_time, all_done
// config    in         cfg_valid & cfg_ready        cfg_index, cfg_data
//
// a load item finishes in its accept cycle; a restart item holds busy while the remaining
// work of each slot is restored, one slot a cycle
// a tick item runs one hold check, an arrival check of each slot scanned plus a priority
// compare for each eligible slot after the first pick, one update, turnaround and waiting on
// completion, then the result cycle; the one shared subtractor serves these steps in turn
// reset clears the time, the remaining work and the held task; the task table is
// undefined until loaded
// the receiver cannot stall: the result is valid only in its strobe cycle
module priority_task_scheduler_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [ptsched_pkg::MODE_W-1:0]      mode,
	input  logic [ptsched_pkg::IDX_W-1:0]       slot,
	input  logic [ptsched_pkg::TIME_W-1:0]      arrival_time,
	input  logic [ptsched_pkg::BURST_W-1:0]     burst_time,
	input  logic [ptsched_pkg::PRIO_W-1:0]      priority_req,
	// result channel
	output logic                                result_valid,
	output logic                                ran,
	output logic [ptsched_pkg::IDX_W-1:0]       task_id,
	output logic                                finished,
	output logic [ptsched_pkg::TIME_W-1:0]      finish_time,
	output logic [ptsched_pkg::TIME_W-1:0]      turnaround_time,
	output logic [ptsched_pkg::TIME_W-1:0]      waiting_time,
	output logic                                all_done,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptsched_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptsched_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int IW = ptsched_pkg::IDX_W;
	localparam int TW = ptsched_pkg::TIME_W;
	localparam int BW = ptsched_pkg::BURST_W;
	localparam int PW = ptsched_pkg::PRIO_W;
	localparam int CW = ptsched_pkg::CNT_W;
	localparam int NT = ptsched_pkg::MAX_TASKS;

	ptsched_pkg::state_t state_q, state_nxt;

	// configuration registers
	logic          preempt_q;
	logic [CW-1:0] pcount_q;
	logic [CW-1:0] n_use;

	// task table
	logic [TW-1:0] arrival_q  [NT];
	logic [BW-1:0] burst_q    [NT];
	logic [PW-1:0] prio_q     [NT];
	logic [BW-1:0] remain_q   [NT];

	// run state
	logic [TW-1:0] tick_q;
	logic          run_valid_q;
	logic [IW-1:0] run_task_q;

	// scan state
	logic [IW-1:0] idx_q;
	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [PW-1:0] best_q;

	// result registers
	logic          ran_q;
	logic          fin_q;
	logic [TW-1:0] ft_q;
	logic [TW-1:0] ta_q;
	logic [TW-1:0] wt_q;

	// shared subtract/compare unit
	logic [TW-1:0] unit_a, unit_b;
	logic [TW:0]   unit_diff;
	logic          unit_borrow;

	logic accept;
	logic hold_ok;
	logic elig;
	logic prio_lt;
	logic last_slot;
	logic fin_now;
	logic done_now;
	ptsched_pkg::mode_t mode_in;

	assign mode_in = ptsched_pkg::mode_t'(mode);
	assign accept  = start && (state_q == ptsched_pkg::ST_IDLE);

	// counts above the table size clamp to the table size
	assign n_use = (pcount_q > ptsched_pkg::COUNT_LIMIT) ? ptsched_pkg::COUNT_LIMIT : pcount_q;

	// configuration writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_q <= 1'b1;
			pcount_q  <= ptsched_pkg::COUNT_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ptsched_pkg::cfg_reg_t'(cfg_index))
				ptsched_pkg::REG_PREEMPT: preempt_q <= cfg_data[0];
				ptsched_pkg::REG_COUNT:   pcount_q  <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// one subtractor serves arrival check, priority compare, turnaround and waiting
	always_comb begin
		unit_a = tick_q;
		unit_b = arrival_q[idx_q];
		case (state_q)
			ptsched_pkg::ST_SCAN_PRI: begin
				unit_a = TW'(prio_q[idx_q]);
				unit_b = TW'(best_q);
			end
			ptsched_pkg::ST_TA: begin
				unit_a = ft_q;
				unit_b = arrival_q[idx_q];
			end
			ptsched_pkg::ST_WT: begin
				unit_a = ta_q;
				unit_b = TW'(burst_q[idx_q]);
			end
			default: begin
				unit_a = tick_q;
				unit_b = arrival_q[idx_q];
			end
		endcase
	end

	assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
	assign unit_borrow = unit_diff[TW];

	// held task in run-to-completion mode, still in range and with work left
	assign hold_ok   = !preempt_q && run_valid_q && ({1'b0, idx_q} < n_use)
		&& (remain_q[idx_q] != '0);
	// arrived (arrival <= tick) and work left
	assign elig      = !unit_borrow && (remain_q[idx_q] != '0);
	// strictly more urgent than the best so far, so ties keep the lower slot
	assign prio_lt   = unit_borrow;
	assign last_slot = ({1'b0, idx_q} == (n_use - CW'(1)));
	assign fin_now   = (remain_q[idx_q] == BW'(1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ptsched_pkg::ST_IDLE: begin
				if (accept && mode_in == ptsched_pkg::MODE_TICK) begin
					state_nxt = ptsched_pkg::ST_HOLD;
				end else if (accept && mode_in == ptsched_pkg::MODE_RESTART) begin
					state_nxt = ptsched_pkg::ST_RESTART;
				end
			end
			ptsched_pkg::ST_RESTART: begin
				if (idx_q == IW'(NT - 1)) begin
					state_nxt = ptsched_pkg::ST_IDLE;
				end
			end
			ptsched_pkg::ST_HOLD: begin
				if (hold_ok || n_use == '0) begin
					state_nxt = ptsched_pkg::ST_UPDATE;
				end else begin
					state_nxt = ptsched_pkg::ST_SCAN_ARR;
				end
			end
			ptsched_pkg::ST_SCAN_ARR: begin
				if (elig && found_q) begin
					state_nxt = ptsched_pkg::ST_SCAN_PRI;
				end else if (last_slot) begin
					state_nxt = ptsched_pkg::ST_UPDATE;
				end
			end
			ptsched_pkg::ST_SCAN_PRI: begin
				if (last_slot) begin
					state_nxt = ptsched_pkg::ST_UPDATE;
				end else begin
					state_nxt = ptsched_pkg::ST_SCAN_ARR;
				end
			end
			ptsched_pkg::ST_UPDATE: begin
				if (found_q && fin_now) begin
					state_nxt = ptsched_pkg::ST_TA;
				end else begin
					state_nxt = ptsched_pkg::ST_DONE;
				end
			end
			ptsched_pkg::ST_TA:   state_nxt = ptsched_pkg::ST_WT;
			ptsched_pkg::ST_WT:   state_nxt = ptsched_pkg::ST_DONE;
			ptsched_pkg::ST_DONE: state_nxt = ptsched_pkg::ST_IDLE;
			default:              state_nxt = ptsched_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptsched_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// handshake outputs
	always_comb begin
		busy         = (state_q != ptsched_pkg::ST_IDLE);
		result_valid = (state_q == ptsched_pkg::ST_DONE);
	end

	// task table writes on load items, no reset
	always_ff @(posedge clk) begin
		if (accept && mode_in == ptsched_pkg::MODE_LOAD) begin
			arrival_q[slot] <= arrival_time;
			burst_q[slot]   <= burst_time;
			prio_q[slot]    <= priority_req;
		end
	end

	// remaining work: load, restart sweep, decrement on run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NT; s++) begin
				remain_q[s] <= '0;
			end
		end else if (accept && mode_in == ptsched_pkg::MODE_LOAD) begin
			remain_q[slot] <= burst_time;
		end else if (state_q == ptsched_pkg::ST_RESTART) begin
			remain_q[idx_q] <= burst_q[idx_q];
		end else if (state_q == ptsched_pkg::ST_UPDATE && found_q) begin
			remain_q[idx_q] <= remain_q[idx_q] - BW'(1);
		end
	end

	// time and held task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			run_valid_q <= 1'b0;
			run_task_q  <= '0;
		end else if (accept && mode_in == ptsched_pkg::MODE_RESTART) begin
			tick_q      <= '0;
			run_valid_q <= 1'b0;
		end else if (state_q == ptsched_pkg::ST_UPDATE) begin
			if (tick_q != ptsched_pkg::TIME_MAX) begin
				tick_q <= tick_q + TW'(1);
			end
			if (found_q) begin
				run_valid_q <= !fin_now;
				run_task_q  <= idx_q;
			end
		end
	end

	// scan sequencer: slot index, current pick and its priority
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= '0;
		end else begin
			case (state_q)
				ptsched_pkg::ST_IDLE: begin
					if (accept && mode_in == ptsched_pkg::MODE_TICK) begin
						idx_q <= run_task_q;
					end else if (accept && mode_in == ptsched_pkg::MODE_RESTART) begin
						idx_q <= '0;
					end
				end
				ptsched_pkg::ST_RESTART: begin
					idx_q <= idx_q + IW'(1);
				end
				ptsched_pkg::ST_HOLD: begin
					if (hold_ok) begin
						found_q <= 1'b1;
						pick_q  <= idx_q;
					end else begin
						found_q <= 1'b0;
						pick_q  <= '0;
						idx_q   <= '0;
					end
				end
				ptsched_pkg::ST_SCAN_ARR: begin
					if (elig && !found_q) begin
						found_q <= 1'b1;
						pick_q  <= idx_q;
						best_q  <= prio_q[idx_q];
					end
					if (!(elig && found_q)) begin
						if (last_slot) begin
							// park on the pick so the update reads its entry
							idx_q <= (elig && !found_q) ? idx_q : pick_q;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ptsched_pkg::ST_SCAN_PRI: begin
					if (prio_lt) begin
						pick_q <= idx_q;
						best_q <= prio_q[idx_q];
					end
					if (last_slot) begin
						idx_q <= prio_lt ? idx_q : pick_q;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ran_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (state_q == ptsched_pkg::ST_UPDATE) begin
			ran_q <= found_q;
			fin_q <= found_q && fin_now;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ptsched_pkg::ST_UPDATE: begin
				ta_q <= '0;
				wt_q <= '0;
				if (found_q && fin_now) begin
					ft_q <= (tick_q != ptsched_pkg::TIME_MAX) ? tick_q + TW'(1) : tick_q;
				end else begin
					ft_q <= '0;
				end
			end
			ptsched_pkg::ST_TA: begin
				ta_q <= unit_borrow ? '0 : unit_diff[TW-1:0];
			end
			ptsched_pkg::ST_WT: begin
				wt_q <= unit_borrow ? '0 : unit_diff[TW-1:0];
			end
			default: ;
		endcase
	end

	// no slot in use has work left
	always_comb begin
		done_now = 1'b1;
		for (int s = 0; s < NT; s++) begin
			if ((CW'(s) < n_use) && (remain_q[s] != '0)) begin
				done_now = 1'b0;
			end
		end
	end

	assign ran             = ran_q;
	assign task_id         = pick_q;
	assign finished        = fin_q;
	assign finish_time     = ft_q;
	assign turnaround_time = ta_q;
	assign waiting_time    = wt_q;
	assign all_done        = done_now;

endmodule
